### rtl/deq_pkg.sv
// deq_pkg: operation and status codes of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

    // operation carried in the request tuser
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_QUERY      = 3'd5
    } t_op;

    // result status
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned OUT_COUNT_W = 5;
    localparam int unsigned OUT_DATA_W  = 80;

endpackage

### rtl/double_ended_queue.sv
// double_ended_queue: bounded deque of 32-bit values in a ring of memory slots
`timescale 1ns / 1ps

// Usage
// The slave channel takes one request per operation: tuser holds the operation
// (push front, push back, pop front, pop back, clear, query) and tdata the value
// a push stores. Every request gives exactly one result on the master channel:
// front and back values (0 when empty), entry count, empty and full flags, and
// a status (done, push refused because full, pop ignored because empty).
// Timing
// Pushes, clear, query and pops that leave no entry: the result is registered in
// the cycle after the request, and a new request is taken every cycle while the
// result side keeps up. Other pops read the new front or back slot through the
// single registered memory read port, then load it into the result in a load state.
// A slot write and the pointer update happen in the request cycle.
// Reset
// Synchronous, active low: the queue is empty, no result is pending. The slot
// memory is not cleared; a slot is only read after a push has written it.
// Stall
// While a result waits for i_m_tready, it holds, and a new request is taken only
// in the cycle in which the waiting result is taken.
module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] element_value
    input  logic [2:0]  i_s_tuser,   // [2:0] operation
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] front_value, [63:32] back_value, [68:64] entry_count,
    // [69] is_empty, [70] is_full, [72:71] status, [79:73] zero
    output logic [deq_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import deq_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    // ring index helpers
    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] prev_idx(input logic [IW-1:0] idx);
        prev_idx = (idx == '0) ? LAST_IDX : idx - IW'(1);
    endfunction

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    t_state             r_state;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [VALUE_W-1:0] r_front, n_front;
    logic [VALUE_W-1:0] r_back, n_back;
    logic               r_load_front;
    t_status            r_status, n_status;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_front;
    logic [VALUE_W-1:0] r_out_back;
    logic [CW-1:0]      r_out_count;
    logic [1:0]         r_out_status;

    logic               accept;
    t_op                op;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               rd_front;
    logic               is_full;
    logic               is_empty;
    logic [31:0]        count_wide;
    logic               out_empty;
    logic               out_full;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign op         = t_op'(i_s_tuser);
    assign is_full    = (r_count == FULL_CNT);
    assign is_empty   = (r_count == '0);

    // next pointers, cached end values and memory access for one request
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_front  = r_front;
        n_back   = r_back;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = prev_idx(r_head);
        rd_en    = 1'b0;
        rd_addr  = next_idx(r_head);
        rd_front = 1'b1;
        case (op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = prev_idx(r_head);
                    n_count = r_count + CW'(1);
                    n_front = i_s_tdata;
                    wr_en   = 1'b1;
                    wr_addr = prev_idx(r_head);
                    if (is_empty) begin
                        n_back = i_s_tdata;
                    end
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail  = next_idx(r_tail);
                    n_count = r_count + CW'(1);
                    n_back  = i_s_tdata;
                    wr_en   = 1'b1;
                    wr_addr = next_idx(r_tail);
                    if (is_empty) begin
                        n_front = i_s_tdata;
                    end
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head   = next_idx(r_head);
                    n_count  = r_count - CW'(1);
                    rd_en    = (r_count != CW'(1));
                    rd_addr  = next_idx(r_head);
                    rd_front = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tail   = prev_idx(r_tail);
                    n_count  = r_count - CW'(1);
                    rd_en    = (r_count != CW'(1));
                    rd_addr  = prev_idx(r_tail);
                    rd_front = 1'b0;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = LAST_IDX;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // slot memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= i_s_tdata;
        end
        if (accept && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // sequencer, queue state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= LAST_IDX;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_head       <= n_head;
                        r_tail       <= n_tail;
                        r_count      <= n_count;
                        r_front      <= n_front;
                        r_back       <= n_back;
                        r_status     <= n_status;
                        r_load_front <= rd_front;
                        if (rd_en) begin
                            r_state     <= S_LOAD;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_front  <= n_front;
                            r_out_back   <= n_back;
                            r_out_count  <= n_count;
                            r_out_status <= n_status;
                        end
                    end else if (r_out_valid && i_m_tready) begin
                        // result taken with no new request
                        r_out_valid <= 1'b0;
                    end
                end
                S_LOAD: begin
                    // the new end value arrives from the memory
                    r_state      <= S_IDLE;
                    r_out_valid  <= 1'b1;
                    r_out_count  <= r_count;
                    r_out_status <= r_status;
                    if (r_load_front) begin
                        r_front     <= r_rd_data;
                        r_out_front <= r_rd_data;
                        r_out_back  <= r_back;
                    end else begin
                        r_back      <= r_rd_data;
                        r_out_front <= r_front;
                        r_out_back  <= r_rd_data;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result packing, end values forced to zero when empty
    assign count_wide = 32'(r_out_count);
    assign out_empty  = (r_out_count == '0);
    assign out_full   = (r_out_count == FULL_CNT);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_status, out_full, out_empty,
                         count_wide[OUT_COUNT_W-1:0],
                         out_empty ? {VALUE_W{1'b0}} : r_out_back,
                         out_empty ? {VALUE_W{1'b0}} : r_out_front};

    // count never exceeds the number of slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    // empty ring keeps the tail just behind the head
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_empty |-> (r_tail == prev_idx(r_head)))
        else $error("head and tail disagree on empty ring");

    // a memory load only runs with the result register free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (!r_out_valid && !o_s_tready))
        else $error("memory load with result pending");

    // an accepted push into a non-full ring grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wr_en) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the count");

endmodule
